[hw/rtl/frame_pacing_limiter_assert.svh]
// assertion macros for the frame pacing limiter
`ifndef FRAME_PACING_LIMITER_ASSERT_SVH
`define FRAME_PACING_LIMITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame pacing limiter assertion failed");
`define FPL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame pacing limiter assertion failed");
`else
`define FPL_ASSERT_IMP(lbl, ante, cons)
`define FPL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/fpl_pkg.sv]
// shared types and constants of the frame pacing limiter
package fpl_pkg;

  localparam int ORIGIN_W   = 32;
  localparam int TIME_W     = 64;
  localparam int DELAY_W    = 16;
  localparam int AVG_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int ELAPSED_W  = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 32;
  localparam int STEP_W     = 5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TICKS  = 8'd0;
  localparam cfg_idx_t REG_SPEED  = 8'd1;
  localparam cfg_idx_t REG_AUX    = 8'd2;
  localparam cfg_idx_t REG_MARGIN = 8'd3;

  localparam logic [1:0]         SPEED_OFF    = 2'd0;
  localparam logic [1:0]         SPEED_HALF   = 2'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0]        MARGIN_RESET = 16'd50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CALC,
    ST_DIV,
    ST_AVG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic calc;
    logic div_step;
    logic push;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic flip;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/fpl_ifs.sv]
// channel interfaces of the frame pacing limiter
interface fpl_in_if;
  import fpl_pkg::*;
  logic                valid;
  logic                ready;
  logic [ORIGIN_W-1:0] frame_origin;
  logic [TIME_W-1:0]   tick_time;
  modport source (output valid, frame_origin, tick_time, input ready);
  modport sink (input valid, frame_origin, tick_time, output ready);
endinterface

interface fpl_out_if;
  import fpl_pkg::*;
  logic               valid;
  logic               ready;
  logic [DELAY_W-1:0] pace_delay;
  logic [AVG_W-1:0]   average_ticks_per_vbl;
  logic [COUNT_W-1:0] vbls_in_frame;
  modport source (output valid, pace_delay, average_ticks_per_vbl, vbls_in_frame,
                  input ready);
  modport sink (input valid, pace_delay, average_ticks_per_vbl, vbls_in_frame,
                output ready);
endinterface

interface fpl_cfg_if;
  import fpl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/frame_pacing_limiter.sv]
// Frame pacing limiter top level. Each input transaction is one vertical blank; a change of
// frame origin counts as a flip and yields one result (elapsed ticks per blank averaged over
// the last HISTORY_DEPTH flips, blank count, pacing delay), other blanks yield none. A blank
// without a flip passes through the evaluate state back to idle; a flip also runs the calc,
// divide, average and output states, the restoring divider giving one quotient bit per cycle,
// and waits while the previous result sits in the output register. Configuration is taken at
// any time with cfg_ch.ready held high and must only change while the block is idle.
`include "frame_pacing_limiter_assert.svh"

module frame_pacing_limiter #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  fpl_in_if.sink     in_ch,
  fpl_out_if.source  out_ch,
  fpl_cfg_if.sink    cfg_ch
);
  import fpl_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  fpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpl_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_origin (in_ch.frame_origin),
    .tick_time    (in_ch.tick_time),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch)
  );

  `FPL_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `FPL_ASSERT_NXT(a_commit_shows_result, cmd.commit, out_ch.valid)
  `FPL_ASSERT_IMP(a_one_command, 1'b1, $onehot0(cmd))

endmodule

[hw/rtl/fpl_ctrl.sv]
// sequencing state machine of the frame pacing limiter
module fpl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fpl_pkg::stat_t stat,
  output fpl_pkg::cmd_t  cmd
);
  import fpl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = stat.flip ? ST_CALC : ST_IDLE;
      ST_CALC: state_nxt = ST_DIV;
      ST_DIV:  if (stat.div_last) state_nxt = ST_AVG;
      ST_AVG:  state_nxt = ST_OUT;
      ST_OUT:  if (stat.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EVAL: cmd.eval = 1'b1;
      ST_CALC: cmd.calc = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_AVG:  cmd.push = 1'b1;
      ST_OUT:  cmd.commit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/fpl_dp.sv]
// datapath: config registers, flip detect, divider, history average, result register
module fpl_dp #(
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fpl_pkg::ORIGIN_W-1:0]   frame_origin,
  input  logic [fpl_pkg::TIME_W-1:0]     tick_time,
  input  fpl_pkg::cmd_t                  cmd,
  output fpl_pkg::stat_t                 stat,
  fpl_cfg_if.sink                        cfg_ch,
  fpl_out_if.source                      out_ch
);
  import fpl_pkg::*;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W = AVG_W + PTR_W;

  // configuration
  logic [31:0] ticks_r;
  logic [1:0]  speed_r;
  logic        aux_r;
  logic [15:0] margin_r;

  // item and frame state
  logic [ORIGIN_W-1:0]  origin_r;
  logic [TIME_W-1:0]    time_r;
  logic [COUNT_W-1:0]   blank_cnt_r;
  logic [ORIGIN_W-1:0]  last_origin_r;
  logic [TIME_W-1:0]    last_flip_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [31:0]          req_r;
  logic [DELAY_W-1:0]   delay_r;

  // divider
  logic [COUNT_W-1:0]   rem_r;
  logic [ELAPSED_W-1:0] quo_r;
  logic [STEP_W-1:0]    step_r;

  // history
  logic [AVG_W-1:0]     ring_r [HISTORY_DEPTH];
  logic [PTR_W-1:0]     ptr_r;
  logic [SUM_W-1:0]     sum_r;

  logic                 out_valid_r;
  logic [DELAY_W-1:0]   out_delay_r;
  logic [AVG_W-1:0]     out_avg_r;
  logic [COUNT_W-1:0]   out_cnt_r;

  logic [47:0]          product;
  logic [31:0]          req_eff;
  logic [31:0]          diff;
  logic                 pace_en;
  logic [COUNT_W:0]     shifted;
  logic [COUNT_W+1:0]   trial;
  logic [SUM_W-1:0]     avg_sum;
  logic [SUM_W-1:0]     sum_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r  <= '0;
      speed_r  <= SPEED_OFF;
      aux_r    <= 1'b0;
      margin_r <= MARGIN_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TICKS:  ticks_r  <= cfg_ch.data;
        REG_SPEED:  speed_r  <= cfg_ch.data[1:0];
        REG_AUX:    aux_r    <= cfg_ch.data[0];
        REG_MARGIN: margin_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign product = ticks_r * blank_cnt_r;
  assign req_eff = (speed_r == SPEED_HALF) ? {req_r[30:0], 1'b0} : req_r;
  assign diff    = req_eff - elapsed_r - {16'b0, margin_r};
  assign pace_en = (speed_r != SPEED_OFF) && !aux_r;

  // one restoring divide step per cycle
  assign shifted = {rem_r, quo_r[ELAPSED_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, blank_cnt_r};

  assign sum_nxt = sum_r - SUM_W'(ring_r[ptr_r]) + SUM_W'(quo_r);
  assign avg_sum = sum_r + SUM_W'(HISTORY_DEPTH / 2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      origin_r <= frame_origin;
      time_r   <= tick_time;
    end
    if (cmd.eval) begin
      elapsed_r <= time_r[ELAPSED_W-1:0] - last_flip_r[ELAPSED_W-1:0];
      req_r     <= product[31:0];
    end
    if (cmd.calc) begin
      delay_r <= (pace_en && diff != '0 && !diff[31]) ? diff[DELAY_W-1:0] : '0;
      rem_r   <= '0;
      quo_r   <= elapsed_r;
      step_r  <= '0;
    end
    if (cmd.div_step) begin
      step_r <= step_r + STEP_W'(1);
      if (!trial[COUNT_W+1]) begin
        rem_r <= trial[COUNT_W-1:0];
        quo_r <= {quo_r[ELAPSED_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[COUNT_W-1:0];
        quo_r <= {quo_r[ELAPSED_W-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      out_delay_r <= delay_r;
      out_avg_r   <= avg_sum[SUM_W-1:PTR_W];
      out_cnt_r   <= blank_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_cnt_r   <= '0;
      last_origin_r <= '0;
      last_flip_r   <= '0;
      ptr_r         <= '0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        ring_r[k] <= '0;
      end
    end else begin
      if (cmd.load && blank_cnt_r != COUNT_MAX) begin
        blank_cnt_r <= blank_cnt_r + COUNT_W'(1);
      end
      if (cmd.push) begin
        ring_r[ptr_r] <= quo_r;
        ptr_r         <= ptr_r + PTR_W'(1);
        sum_r         <= sum_nxt;
      end
      if (cmd.commit) begin
        last_origin_r <= origin_r;
        last_flip_r   <= time_r + {{(TIME_W-DELAY_W){1'b0}}, delay_r};
        blank_cnt_r   <= '0;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.flip     = (origin_r != last_origin_r);
  assign stat.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.pace_delay            = out_delay_r;
  assign out_ch.average_ticks_per_vbl = out_avg_r;
  assign out_ch.vbls_in_frame         = out_cnt_r;

endmodule
